>>> rtl/core/fgn_pkg.sv
// ----------------------------------------------------------------------------
// fgn_pkg
// Types, widths and codes shared by the fractal gradient noise core.
// ----------------------------------------------------------------------------
package fgn_pkg;

    // number formats
    localparam int FRAC_BITS   = 16;
    localparam int IDX_W       = 8;
    localparam int MAX_OCTAVES = 16;
    localparam int OCT_W       = 5;
    localparam int GRAD_W      = 16;
    localparam int GRAD_FRAC   = 15;
    localparam int COORD_W     = 32;
    localparam int VAL_W       = 21;
    localparam int DIFF_W      = 22;
    localparam int FADE_W      = 17;
    localparam int ACC_W       = 35;
    localparam int MUL_A_W     = 33;
    localparam int MUL_B_W     = 25;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int SCALE_W     = 41;
    localparam int PART_W      = 45;
    localparam int FULL_W      = 65;
    localparam int DVD_W       = VAL_W + FRAC_BITS;
    localparam int REM_W       = SCALE_W;
    localparam int SUM_W       = 44;
    localparam int CFG_W       = 24;
    localparam int OUT_W       = 32;

    localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1) << FRAC_BITS;
    localparam logic [SCALE_W-1:0] SCALE_CAP = SCALE_W'(1) << 40;

    // input item kinds
    localparam logic [2:0] ACT_LOAD_PERM = 3'd0;
    localparam logic [2:0] ACT_LOAD_G1   = 3'd1;
    localparam logic [2:0] ACT_LOAD_G2   = 3'd2;
    localparam logic [2:0] ACT_LOAD_G3   = 3'd3;
    localparam logic [2:0] ACT_EVAL      = 3'd4;

    // register indexes
    localparam logic [2:0] CFG_OCTAVES = 3'd0;
    localparam logic [2:0] CFG_ALPHA   = 3'd1;
    localparam logic [2:0] CFG_BETA    = 3'd2;
    localparam logic [2:0] CFG_DIMS    = 3'd3;
    localparam logic [2:0] CFG_ABS     = 3'd4;

    // register reset values
    localparam logic [OCT_W-1:0] OCTAVES_RST = 5'd1;
    localparam logic [CFG_W-1:0] ALPHA_RST   = 24'h020000;
    localparam logic [CFG_W-1:0] BETA_RST    = 24'h020000;
    localparam logic [1:0]       DIMS_RST    = 2'd3;

    typedef enum logic [1:0] {
        DIM_1,
        DIM_2,
        DIM_3
    } dim_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PERM,
        ST_FADE_SQ,
        ST_FADE_CU,
        ST_GRD_RD,
        ST_DOT,
        ST_BLEND_SUB,
        ST_BLEND_MUL,
        ST_DIV,
        ST_ACC,
        ST_SCALE_LO,
        ST_SCALE_HI,
        ST_GROW,
        ST_FINISH
    } state_t;

endpackage

>>> rtl/core/fractal_gradient_noise_core.sv
// ----------------------------------------------------------------------------
// fractal_gradient_noise_core
// Fixed-point multi-octave lattice gradient noise with table load items.
// ----------------------------------------------------------------------------
// A load item writes one entry of the permutation or a gradient table.
// An evaluate item runs all octaves on one shared 33x25 multiplier and a
// one-bit-per-cycle restoring divider; besides the division, each octave
// does table reads, fade, gradient dot products, blends, the scale update
// and coordinate growth, one multiply per cycle. The input is not ready
// during an evaluation; one finished result can wait in the output
// register while the next item is taken. Tables need no clearing and are
// only meaningful once written.
module fractal_gradient_noise_core
    import fgn_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    // input items
    input  logic           s_tvalid,
    output logic           s_tready,
    // table_index[7:0], perm_value[15:8], grad_x[31:16], grad_y[47:32],
    // grad_z[63:48], coord_x[95:64], coord_y[127:96], coord_z[159:128]
    input  logic [159:0]   s_tdata,
    // action[2:0]
    input  logic [2:0]     s_tuser,
    // results
    output logic           m_tvalid,
    input  logic           m_tready,
    // noise_value[31:0]
    output logic [31:0]    m_tdata,
    // saturated[0]
    output logic           m_tuser,
    // register writes
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [2:0]     cfg_index,
    input  logic [23:0]    cfg_data
);

    // input fields
    logic [IDX_W-1:0]         table_index;
    logic [IDX_W-1:0]         perm_value;
    logic signed [GRAD_W-1:0] grad_x, grad_y, grad_z;
    logic [COORD_W-1:0]       coord_x, coord_y, coord_z;
    logic                     s_accept;

    assign table_index = s_tdata[7:0];
    assign perm_value  = s_tdata[15:8];
    assign grad_x      = s_tdata[31:16];
    assign grad_y      = s_tdata[47:32];
    assign grad_z      = s_tdata[63:48];
    assign coord_x     = s_tdata[95:64];
    assign coord_y     = s_tdata[127:96];
    assign coord_z     = s_tdata[159:128];
    assign s_accept    = s_tvalid && s_tready;

    // configuration registers
    logic [OCT_W-1:0] octave_count_reg;
    logic [CFG_W-1:0] amplitude_divisor_reg;
    logic [CFG_W-1:0] frequency_multiplier_reg;
    logic [1:0]       dimensions_reg;
    logic             absolute_mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_count_reg         <= OCTAVES_RST;
            amplitude_divisor_reg    <= ALPHA_RST;
            frequency_multiplier_reg <= BETA_RST;
            dimensions_reg           <= DIMS_RST;
            absolute_mode_reg        <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_OCTAVES: octave_count_reg         <= cfg_data[OCT_W-1:0];
                CFG_ALPHA:   amplitude_divisor_reg    <= cfg_data;
                CFG_BETA:    frequency_multiplier_reg <= cfg_data;
                CFG_DIMS:    dimensions_reg           <= cfg_data[1:0];
                CFG_ABS:     absolute_mode_reg        <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    // sequencer and datapath registers
    state_t                    state_reg, state_next;
    dim_t                      dim_reg, dim_next;
    logic [OCT_W-1:0]          oct_cnt_reg, oct_cnt_next;
    logic [OCT_W-1:0]          oct_num_reg, oct_num_next;
    logic [2:0]                step_reg, step_next;
    logic [1:0]                comp_reg, comp_next;
    logic [3:0]                vcnt_reg, vcnt_next;
    logic [5:0]                div_cnt_reg, div_cnt_next;
    logic [COORD_W-1:0]        cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic [FADE_W-1:0]         t2_reg, t2_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [DIFF_W-1:0]  diff_reg, diff_next;
    logic [SCALE_W-1:0]        scale_reg, scale_next;
    logic [PART_W-1:0]         pl_reg, pl_next;
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic [DVD_W-1:0]          dvd_reg, dvd_next;
    logic                      neg_reg, neg_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]          noise_reg, noise_next;
    logic                      sat_reg, sat_next;

    logic [IDX_W-1:0]          pv_reg [6];
    logic [IDX_W-1:0]          pv_next [6];
    logic [FADE_W-1:0]         fade_reg [3];
    logic [FADE_W-1:0]         fade_next [3];
    logic signed [VAL_W-1:0]   v_reg [8];
    logic signed [VAL_W-1:0]   v_next [8];

    // table memories
    logic [IDX_W-1:0]          perm_mem [256];
    logic [GRAD_W-1:0]         g1_mem [256];
    logic [2*GRAD_W-1:0]       g2_mem [256];
    logic [3*GRAD_W-1:0]       g3_mem [256];
    logic [IDX_W-1:0]          perm_rd_reg;
    logic [GRAD_W-1:0]         g1_rd_reg;
    logic [2*GRAD_W-1:0]       g2_rd_reg;
    logic [3*GRAD_W-1:0]       g3_rd_reg;
    logic [IDX_W-1:0]          perm_addr;
    logic [IDX_W-1:0]          grad_addr;
    logic                      grad_rd_en;

    // shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    assign prod = mul_a * mul_b;

    // lattice cells and offsets
    logic [IDX_W-1:0]          bx0, bx1, by0, by1, bz0, bz1;
    logic signed [17:0]        rx0, rx1, ry0, ry1, rz0, rz1;

    assign bx0 = cx_reg[23:16];
    assign by0 = cy_reg[23:16];
    assign bz0 = cz_reg[23:16];
    assign bx1 = bx0 + 8'd1;
    assign by1 = by0 + 8'd1;
    assign bz1 = bz0 + 8'd1;
    assign rx0 = $signed({2'b00, cx_reg[15:0]});
    assign ry0 = $signed({2'b00, cy_reg[15:0]});
    assign rz0 = $signed({2'b00, cz_reg[15:0]});
    assign rx1 = rx0 - 18'sd65536;
    assign ry1 = ry0 - 18'sd65536;
    assign rz1 = rz0 - 18'sd65536;

    // per-dimension counts
    logic [2:0] nperm;
    logic [1:0] ndim;
    logic [3:0] ncorner;

    always_comb
    begin
        unique case (dim_reg)
            DIM_1:   begin nperm = 3'd2; ndim = 2'd1; ncorner = 4'd2; end
            DIM_2:   begin nperm = 3'd6; ndim = 2'd2; ncorner = 4'd4; end
            default: begin nperm = 3'd6; ndim = 2'd3; ncorner = 4'd8; end
        endcase
    end

    // selections driven by the step counter
    logic [COORD_W-1:0]       coord_sel;
    logic [2:0]               pv_idx;
    logic signed [17:0]       r_sel;
    logic signed [GRAD_W-1:0] g_sel;
    logic [1:0]               level;
    logic signed [MUL_B_W-1:0] fade_k;

    always_comb
    begin
        unique case (step_reg[1:0])
            2'd0:    coord_sel = cx_reg;
            2'd1:    coord_sel = cy_reg;
            default: coord_sel = cz_reg;
        endcase
    end

    assign fade_k = 25'sd196608 - $signed(MUL_B_W'({coord_sel[15:0], 1'b0}));

    // corner step_reg: bit 0 picks x1, bit 1 y1, bit 2 z1
    assign pv_idx = (dim_reg == DIM_1) ? {2'b00, step_reg[0]}
                                       : 3'(3'd2 + {1'b0, step_reg[1:0]});
    assign grad_addr = pv_reg[pv_idx]
                     + ((dim_reg == DIM_3) ? (step_reg[2] ? bz1 : bz0) : 8'd0);
    assign grad_rd_en = (state_reg == ST_GRD_RD);

    always_comb
    begin
        unique case (comp_reg)
            2'd0:    r_sel = step_reg[0] ? rx1 : rx0;
            2'd1:    r_sel = step_reg[1] ? ry1 : ry0;
            default: r_sel = step_reg[2] ? rz1 : rz0;
        endcase
        priority if (dim_reg == DIM_1)
            g_sel = g1_rd_reg;
        else if (dim_reg == DIM_2)
            g_sel = comp_reg[0] ? g2_rd_reg[31:16] : g2_rd_reg[15:0];
        else
        begin
            unique case (comp_reg)
                2'd0:    g_sel = g3_rd_reg[15:0];
                2'd1:    g_sel = g3_rd_reg[31:16];
                default: g_sel = g3_rd_reg[47:32];
            endcase
        end
    end

    // blend level from the blend step
    always_comb
    begin
        unique case (dim_reg)
            DIM_1:   level = 2'd0;
            DIM_2:   level = (step_reg < 3'd2) ? 2'd0 : 2'd1;
            default: level = (step_reg < 3'd4) ? 2'd0 : ((step_reg < 3'd6) ? 2'd1 : 2'd2);
        endcase
    end

    // permutation read address
    always_comb
    begin
        unique case (step_reg)
            3'd0:    perm_addr = bx0;
            3'd1:    perm_addr = bx1;
            3'd2:    perm_addr = pv_reg[0] + by0;
            3'd3:    perm_addr = pv_reg[1] + by0;
            3'd4:    perm_addr = pv_reg[0] + by1;
            default: perm_addr = pv_reg[1] + by1;
        endcase
    end

    // multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_FADE_SQ:
            begin
                mul_a = MUL_A_W'($signed({1'b0, coord_sel[15:0]}));
                mul_b = MUL_B_W'($signed({1'b0, coord_sel[15:0]}));
            end
            ST_FADE_CU:
            begin
                mul_a = MUL_A_W'($signed({1'b0, t2_reg}));
                mul_b = fade_k;
            end
            ST_DOT:
            begin
                mul_a = MUL_A_W'(r_sel);
                mul_b = MUL_B_W'(g_sel);
            end
            ST_BLEND_MUL:
            begin
                mul_a = MUL_A_W'($signed({1'b0, fade_reg[level]}));
                mul_b = MUL_B_W'(diff_reg);
            end
            ST_SCALE_LO:
            begin
                mul_a = MUL_A_W'($signed({1'b0, scale_reg[19:0]}));
                mul_b = $signed({1'b0, amplitude_divisor_reg});
            end
            ST_SCALE_HI:
            begin
                mul_a = MUL_A_W'($signed({1'b0, scale_reg[40:20]}));
                mul_b = $signed({1'b0, amplitude_divisor_reg});
            end
            ST_GROW:
            begin
                mul_a = MUL_A_W'($signed(coord_sel));
                mul_b = $signed({1'b0, frequency_multiplier_reg});
            end
            default: ;
        endcase
    end

    // datapath helpers
    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [VAL_W-1:0]  blend_res;
    logic signed [VAL_W-1:0]  val_fin;
    logic [VAL_W-1:0]         val_mag;
    logic [REM_W:0]           rem_sh;
    logic                     rem_ge;
    logic [FULL_W-1:0]        scale_full;
    logic [48:0]              scale_shr;
    logic [SCALE_W-1:0]       scale_new;
    logic signed [SUM_W-1:0]  q_ext;

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-64'sd2147483648);

    assign acc_sum   = acc_reg + ACC_W'(prod);
    assign blend_res = v_reg[0] + VAL_W'(prod >>> FRAC_BITS);
    assign val_fin   = (dim_reg == DIM_3 && absolute_mode_reg && blend_res < 0)
                     ? -blend_res : blend_res;
    assign val_mag   = val_fin[VAL_W-1] ? VAL_W'(-val_fin) : VAL_W'(val_fin);
    assign rem_sh    = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_ge    = rem_sh >= {1'b0, scale_reg};
    assign scale_full = (FULL_W'(prod[PART_W-1:0]) << 20) + FULL_W'(pl_reg);
    assign scale_shr = scale_full[FULL_W-1:FRAC_BITS];
    assign q_ext     = $signed(SUM_W'(dvd_reg));

    always_comb
    begin
        if (scale_shr > 49'(SCALE_CAP))
            scale_new = SCALE_CAP;
        else if (scale_shr == '0)
            scale_new = SCALE_W'(1);
        else
            scale_new = scale_shr[SCALE_W-1:0];
    end

    assign s_tready = (state_reg == ST_IDLE);

    // next state and datapath
    always_comb
    begin
        state_next    = state_reg;
        dim_next      = dim_reg;
        oct_cnt_next  = oct_cnt_reg;
        oct_num_next  = oct_num_reg;
        step_next     = step_reg;
        comp_next     = comp_reg;
        vcnt_next     = vcnt_reg;
        div_cnt_next  = div_cnt_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        cz_next       = cz_reg;
        t2_next       = t2_reg;
        acc_next      = acc_reg;
        diff_next     = diff_reg;
        scale_next    = scale_reg;
        pl_next       = pl_reg;
        rem_next      = rem_reg;
        dvd_next      = dvd_reg;
        neg_next      = neg_reg;
        sum_next      = sum_reg;
        noise_next    = noise_reg;
        sat_next      = sat_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        pv_next       = pv_reg;
        fade_next     = fade_reg;
        v_next        = v_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept && s_tuser == ACT_EVAL)
                begin
                    cx_next      = coord_x;
                    cy_next      = coord_y;
                    cz_next      = coord_z;
                    scale_next   = SCALE_ONE;
                    sum_next     = '0;
                    oct_cnt_next = '0;
                    step_next    = '0;
                    oct_num_next = (octave_count_reg > OCT_W'(MAX_OCTAVES))
                                 ? OCT_W'(MAX_OCTAVES) : octave_count_reg;
                    priority if (dimensions_reg == 2'd1)
                        dim_next = DIM_1;
                    else if (dimensions_reg == 2'd2)
                        dim_next = DIM_2;
                    else
                        dim_next = DIM_3;
                    state_next = (octave_count_reg == '0) ? ST_FINISH : ST_PERM;
                end
            end

            // issue one read a cycle, capture the one before
            ST_PERM:
            begin
                if (step_reg != 3'd0)
                    pv_next[3'(step_reg - 3'd1)] = perm_rd_reg;
                if (step_reg == nperm)
                begin
                    step_next  = '0;
                    state_next = ST_FADE_SQ;
                end
                else
                    step_next = step_reg + 3'd1;
            end

            ST_FADE_SQ:
            begin
                t2_next    = prod[FRAC_BITS +: FADE_W];
                state_next = ST_FADE_CU;
            end

            ST_FADE_CU:
            begin
                fade_next[step_reg[1:0]] = prod[FRAC_BITS +: FADE_W];
                if (step_reg[1:0] == ndim - 2'd1)
                begin
                    step_next  = '0;
                    state_next = ST_GRD_RD;
                end
                else
                begin
                    step_next  = step_reg + 3'd1;
                    state_next = ST_FADE_SQ;
                end
            end

            ST_GRD_RD:
            begin
                comp_next  = '0;
                acc_next   = '0;
                state_next = ST_DOT;
            end

            // one gradient component per cycle
            ST_DOT:
            begin
                if (comp_reg == ndim - 2'd1)
                begin
                    v_next[step_reg] = VAL_W'(acc_sum >>> GRAD_FRAC);
                    if ({1'b0, step_reg} == ncorner - 4'd1)
                    begin
                        step_next  = '0;
                        vcnt_next  = ncorner;
                        state_next = ST_BLEND_SUB;
                    end
                    else
                    begin
                        step_next  = step_reg + 3'd1;
                        state_next = ST_GRD_RD;
                    end
                end
                else
                begin
                    comp_next = comp_reg + 2'd1;
                    acc_next  = acc_sum;
                end
            end

            ST_BLEND_SUB:
            begin
                diff_next  = DIFF_W'(v_reg[1]) - DIFF_W'(v_reg[0]);
                state_next = ST_BLEND_MUL;
            end

            // pop two from the head, push the blend at the tail
            ST_BLEND_MUL:
            begin
                for (int i = 0; i < 6; i++)
                    v_next[i] = v_reg[i+2];
                v_next[3'(vcnt_reg - 4'd2)] = blend_res;
                vcnt_next = vcnt_reg - 4'd1;
                step_next = step_reg + 3'd1;
                if (vcnt_reg == 4'd2)
                begin
                    neg_next     = val_fin[VAL_W-1];
                    dvd_next     = {val_mag, FRAC_BITS'(0)};
                    rem_next     = '0;
                    div_cnt_next = '0;
                    state_next   = ST_DIV;
                end
                else
                    state_next = ST_BLEND_SUB;
            end

            // restoring division, one quotient bit a cycle
            ST_DIV:
            begin
                rem_next     = rem_ge ? REM_W'(rem_sh - {1'b0, scale_reg})
                                      : REM_W'(rem_sh);
                dvd_next     = {dvd_reg[DVD_W-2:0], rem_ge};
                div_cnt_next = div_cnt_reg + 6'd1;
                if (div_cnt_reg == 6'(DVD_W - 1))
                    state_next = ST_ACC;
            end

            ST_ACC:
            begin
                sum_next   = neg_reg ? sum_reg - q_ext : sum_reg + q_ext;
                step_next  = '0;
                state_next = (scale_reg < SCALE_CAP) ? ST_SCALE_LO : ST_GROW;
            end

            ST_SCALE_LO:
            begin
                pl_next    = prod[PART_W-1:0];
                state_next = ST_SCALE_HI;
            end

            ST_SCALE_HI:
            begin
                scale_next = scale_new;
                state_next = ST_GROW;
            end

            ST_GROW:
            begin
                unique case (step_reg[1:0])
                    2'd0:    cx_next = prod[FRAC_BITS +: COORD_W];
                    2'd1:    cy_next = prod[FRAC_BITS +: COORD_W];
                    default: cz_next = prod[FRAC_BITS +: COORD_W];
                endcase
                if (step_reg == 3'd2)
                begin
                    step_next    = '0;
                    oct_cnt_next = oct_cnt_reg + 5'd1;
                    state_next   = (oct_cnt_reg + 5'd1 == oct_num_reg) ? ST_FINISH : ST_PERM;
                end
                else
                    step_next = step_reg + 3'd1;
            end

            // clamp and hand over once the output register is free
            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    priority if (sum_reg > SUM_MAX)
                    begin
                        noise_next = OUT_W'(SUM_MAX);
                        sat_next   = 1'b1;
                    end
                    else if (sum_reg < SUM_MIN)
                    begin
                        noise_next = OUT_W'(SUM_MIN);
                        sat_next   = 1'b1;
                    end
                    else
                    begin
                        noise_next = OUT_W'(sum_reg);
                        sat_next   = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            dim_reg      <= DIM_3;
            oct_cnt_reg  <= '0;
            oct_num_reg  <= '0;
            step_reg     <= '0;
            comp_reg     <= '0;
            vcnt_reg     <= '0;
            div_cnt_reg  <= '0;
            scale_reg    <= SCALE_ONE;
            rem_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            dim_reg      <= dim_next;
            oct_cnt_reg  <= oct_cnt_next;
            oct_num_reg  <= oct_num_next;
            step_reg     <= step_next;
            comp_reg     <= comp_next;
            vcnt_reg     <= vcnt_next;
            div_cnt_reg  <= div_cnt_next;
            scale_reg    <= scale_next;
            rem_reg      <= rem_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        cz_reg    <= cz_next;
        t2_reg    <= t2_next;
        acc_reg   <= acc_next;
        diff_reg  <= diff_next;
        pl_reg    <= pl_next;
        dvd_reg   <= dvd_next;
        neg_reg   <= neg_next;
        sum_reg   <= sum_next;
        noise_reg <= noise_next;
        sat_reg   <= sat_next;
        pv_reg    <= pv_next;
        fade_reg  <= fade_next;
        v_reg     <= v_next;
    end

    // table writes from load items, registered reads
    always_ff @(posedge clk)
    begin
        if (s_accept && s_tuser == ACT_LOAD_PERM)
            perm_mem[table_index] <= perm_value;
        if (s_accept && s_tuser == ACT_LOAD_G1)
            g1_mem[table_index] <= grad_x;
        if (s_accept && s_tuser == ACT_LOAD_G2)
            g2_mem[table_index] <= {grad_y, grad_x};
        if (s_accept && s_tuser == ACT_LOAD_G3)
            g3_mem[table_index] <= {grad_z, grad_y, grad_x};
        perm_rd_reg <= perm_mem[perm_addr];
        if (grad_rd_en)
        begin
            g1_rd_reg <= g1_mem[grad_addr];
            g2_rd_reg <= g2_mem[grad_addr];
            g3_rd_reg <= g3_mem[grad_addr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = noise_reg;
    assign m_tuser  = sat_reg;

`ifndef ASSERT_OFF
    // running scale stays within its clamped range
    a_scale_range: assert property (@(posedge clk) disable iff (!rst_n)
        scale_reg != '0 && scale_reg <= SCALE_CAP)
        else $error("scale out of range");

    // partial remainder stays below the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < scale_reg))
        else $error("divider remainder not reduced");

    // blend queue always holds a pair to combine
    a_blend_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BLEND_MUL) |-> (vcnt_reg >= 4'd2 && vcnt_reg <= 4'd8))
        else $error("blend queue count out of range");
`endif

endmodule
